// ----- hdl/gtp_pkg.sv -----
// ----------------------------------------------------------------------------
// gtp_pkg
// shared constants, types and the power product schedule of the tone detector
// ----------------------------------------------------------------------------
package gtp_pkg;

    localparam int ACC_BITS      = 48;
    localparam int COEFF_BITS    = 19;
    localparam int FRAC_BITS     = 16;
    localparam int WLEN_BITS     = 13;
    localparam int POWER_BITS    = 63;
    localparam int PIECE_BITS    = 24;
    localparam int MUL_BITS      = PIECE_BITS + 1;
    localparam int PROD_BITS     = 2 * MUL_BITS;
    localparam int CPROD_BITS    = COEFF_BITS + ACC_BITS;
    localparam int PACC_BITS     = 116;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 19;
    localparam int WLEN_RESET    = 256;
    localparam int PWR_OPS       = 12;
    localparam int STEP_BITS     = 4;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_TONE_COEFF    = 1'b0,
        CFG_WINDOW_LENGTH = 1'b1
    } t_cfg_idx;

    // operand pieces fed to the shared multiplier
    typedef enum logic [2:0] {
        OPND_A1L,
        OPND_A1H,
        OPND_A2L,
        OPND_A2H,
        OPND_K0,
        OPND_K1,
        OPND_K2,
        OPND_COEFF
    } t_opnd;

    typedef enum logic [2:0] {
        SH_0,
        SH_16,
        SH_24,
        SH_41,
        SH_48,
        SH_64,
        SH_72
    } t_shift;

    typedef struct packed {
        t_opnd  opnd_a;
        t_opnd  opnd_b;
        t_shift shift;
        logic   sub;
    } t_mac_op;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    // power = (a1^2 + a2^2) * 2^16 - (coeff * a2) * a1, built from 24-bit pieces
    function automatic t_mac_op pwr_op(input logic [STEP_BITS-1:0] idx);
        t_mac_op op;
        unique case (idx)
            4'd0:    op = '{OPND_A1H, OPND_A1H, SH_64, 1'b0};
            4'd1:    op = '{OPND_A1H, OPND_A1L, SH_41, 1'b0};
            4'd2:    op = '{OPND_A1L, OPND_A1L, SH_16, 1'b0};
            4'd3:    op = '{OPND_A2H, OPND_A2H, SH_64, 1'b0};
            4'd4:    op = '{OPND_A2H, OPND_A2L, SH_41, 1'b0};
            4'd5:    op = '{OPND_A2L, OPND_A2L, SH_16, 1'b0};
            4'd6:    op = '{OPND_K0, OPND_A1L, SH_0, 1'b1};
            4'd7:    op = '{OPND_K0, OPND_A1H, SH_24, 1'b1};
            4'd8:    op = '{OPND_K1, OPND_A1L, SH_24, 1'b1};
            4'd9:    op = '{OPND_K1, OPND_A1H, SH_48, 1'b1};
            4'd10:   op = '{OPND_K2, OPND_A1L, SH_48, 1'b1};
            4'd11:   op = '{OPND_K2, OPND_A1H, SH_72, 1'b1};
            default: op = '{OPND_A1L, OPND_A1L, SH_0, 1'b0};
        endcase
        return op;
    endfunction

endpackage

// ----- hdl/gtp_fifo.sv -----
// ----------------------------------------------------------------------------
// gtp_fifo
// short item queue between the sample front end and the arithmetic back end
// ----------------------------------------------------------------------------
module gtp_fifo #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr,
    input  logic [WIDTH-1:0]    i_wdata,
    input  logic                i_rd,
    output logic [WIDTH-1:0]    o_rdata,
    output gtp_pkg::t_q_stat    o_stat
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CNTW-1:0]  r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNTW'(DEPTH));
    assign wr_en        = i_wr && !o_stat.full;
    assign rd_en        = i_rd && !o_stat.empty;
    assign o_rdata      = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- hdl/gtp_front.sv -----
// ----------------------------------------------------------------------------
// gtp_front
// sample intake: counts the window and tags the item that closes it
// ----------------------------------------------------------------------------
module gtp_front #(
    parameter int MAX_WINDOW  = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic [gtp_pkg::WLEN_BITS-1:0] i_wlen,
    input  gtp_pkg::t_q_stat              i_q_stat,
    output logic                          o_full,
    output logic                          o_q_wr,
    output logic [SAMPLE_BITS:0]          o_q_data
);

    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int LW = (CW > gtp_pkg::WLEN_BITS) ? CW : gtp_pkg::WLEN_BITS;

    logic [CW-1:0] r_count;
    logic [LW-1:0] wl_ext;
    logic [LW-1:0] max_ext;
    logic [LW-1:0] len;
    logic [LW-1:0] cnt_inc;
    logic          last;

    assign wl_ext  = LW'(i_wlen);
    assign max_ext = LW'(MAX_WINDOW);
    assign cnt_inc = LW'(r_count) + 1'b1;

    always_comb begin
        priority if (wl_ext == '0) begin
            len = LW'(1);
        end else if (wl_ext > max_ext) begin
            len = max_ext;
        end else begin
            len = wl_ext;
        end
    end

    assign last     = (cnt_inc >= len);
    assign o_full   = i_q_stat.full;
    assign o_q_wr   = i_push && !i_q_stat.full;
    assign o_q_data = {last, i_sample};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (o_q_wr) begin
            r_count <= last ? '0 : CW'(cnt_inc);
        end
    end

endmodule

// ----- hdl/gtp_mul.sv -----
// ----------------------------------------------------------------------------
// gtp_mul
// shared signed 25x25 multiplier with registered product
// ----------------------------------------------------------------------------
module gtp_mul (
    input  logic                                 i_clk,
    input  logic signed [gtp_pkg::MUL_BITS-1:0]  i_a,
    input  logic signed [gtp_pkg::MUL_BITS-1:0]  i_b,
    output logic signed [gtp_pkg::PROD_BITS-1:0] o_p
);

    logic signed [gtp_pkg::PROD_BITS-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ----- hdl/gtp_back.sv -----
// ----------------------------------------------------------------------------
// gtp_back
// accumulator update, bin power sequence and result register
// ----------------------------------------------------------------------------
module gtp_back #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic signed [gtp_pkg::COEFF_BITS-1:0] i_coeff,
    input  logic [SAMPLE_BITS:0]                  i_q_data,
    input  gtp_pkg::t_q_stat                      i_q_stat,
    output logic                                  o_q_rd,
    input  logic                                  i_pop,
    output logic                                  o_empty,
    output logic [gtp_pkg::POWER_BITS-1:0]        o_bin_power,
    output logic                                  o_overflow
);

    localparam int ACC_BITS  = gtp_pkg::ACC_BITS;
    localparam int PB        = gtp_pkg::PIECE_BITS;
    localparam int MB        = gtp_pkg::MUL_BITS;
    localparam int KB        = gtp_pkg::CPROD_BITS;
    localparam int PAB       = gtp_pkg::PACC_BITS;
    localparam int FB        = gtp_pkg::FRAC_BITS;
    localparam int POWB      = gtp_pkg::POWER_BITS;
    localparam int SB        = gtp_pkg::STEP_BITS;
    localparam int TERM_BITS = KB - FB;
    localparam int SUM_BITS  = TERM_BITS + 2;

    localparam logic signed [KB-1:0]       K_HALF   = KB'(1) <<< (FB - 1);
    localparam logic signed [PAB-1:0]      P_HALF   = PAB'(1) <<< (FB - 1);
    localparam logic signed [SUM_BITS-1:0] ACC_MAX  = (SUM_BITS'(1) <<< (ACC_BITS - 1)) - 1;
    localparam logic signed [SUM_BITS-1:0] ACC_MIN  = -ACC_MAX - 1;
    localparam logic [SB-1:0]              UPD_LAST = SB'(3);
    localparam logic [SB-1:0]              PWR_END  = SB'(gtp_pkg::PWR_OPS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPD,
        ST_PWR,
        ST_OUT
    } t_state;

    t_state                        r_state;
    logic [SB-1:0]                 r_step;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic                          r_last;
    logic signed [ACC_BITS-1:0]    r_a1;
    logic signed [ACC_BITS-1:0]    r_a2;
    logic signed [KB-1:0]          r_k;
    logic signed [PAB-1:0]         r_acc;
    logic                          r_sat;
    logic                          r_out_valid;
    logic [POWB-1:0]               r_power;
    logic                          r_ovf;

    logic                          q_take;
    gtp_pkg::t_opnd                sel_a;
    gtp_pkg::t_opnd                sel_b;
    gtp_pkg::t_mac_op              iss_op;
    gtp_pkg::t_mac_op              acc_op;
    logic signed [MB-1:0]          mul_a;
    logic signed [MB-1:0]          mul_b;
    logic signed [gtp_pkg::PROD_BITS-1:0] mul_p;
    logic signed [PAB-1:0]         p_ext;
    logic signed [PAB-1:0]         addend;
    logic signed [PAB-1:0]         acc_next;
    logic signed [KB-1:0]          k_rnd;
    logic signed [TERM_BITS-1:0]   term;
    logic signed [SUM_BITS-1:0]    nv_wide;
    logic signed [ACC_BITS-1:0]    nv_sat;
    logic                          nv_ovf;
    logic                          acc_neg;
    logic                          acc_big;
    logic [POWB-1:0]               power;

    function automatic logic signed [MB-1:0] opnd_val(
        input gtp_pkg::t_opnd              sel,
        input logic signed [ACC_BITS-1:0]  a1,
        input logic signed [ACC_BITS-1:0]  a2,
        input logic signed [KB-1:0]        k,
        input logic signed [gtp_pkg::COEFF_BITS-1:0] c
    );
        logic signed [MB-1:0] v;
        unique case (sel)
            gtp_pkg::OPND_A1L:   v = {1'b0, a1[PB-1:0]};
            gtp_pkg::OPND_A1H:   v = MB'(signed'(a1[ACC_BITS-1:PB]));
            gtp_pkg::OPND_A2L:   v = {1'b0, a2[PB-1:0]};
            gtp_pkg::OPND_A2H:   v = MB'(signed'(a2[ACC_BITS-1:PB]));
            gtp_pkg::OPND_K0:    v = {1'b0, k[PB-1:0]};
            gtp_pkg::OPND_K1:    v = {1'b0, k[2*PB-1:PB]};
            gtp_pkg::OPND_K2:    v = MB'(signed'(k[KB-1:2*PB]));
            gtp_pkg::OPND_COEFF: v = MB'(c);
            default:             v = '0;
        endcase
        return v;
    endfunction

    assign q_take = !i_q_stat.empty &&
                    ((r_state == ST_IDLE) ||
                     ((r_state == ST_UPD) && (r_step == UPD_LAST) && !r_last));
    assign o_q_rd = q_take;

    // operand selection for the shared multiplier
    assign iss_op = gtp_pkg::pwr_op(r_step);
    assign acc_op = gtp_pkg::pwr_op(r_step - 1'b1);

    always_comb begin
        if (r_state == ST_PWR) begin
            sel_a = iss_op.opnd_a;
            sel_b = iss_op.opnd_b;
        end else begin
            sel_a = gtp_pkg::OPND_COEFF;
            sel_b = (r_step == SB'(1)) ? gtp_pkg::OPND_A1H : gtp_pkg::OPND_A1L;
        end
    end

    assign mul_a = opnd_val(sel_a, r_a1, r_a2, r_k, i_coeff);
    assign mul_b = opnd_val(sel_b, r_a1, r_a2, r_k, i_coeff);

    gtp_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // power accumulation
    assign p_ext = PAB'(mul_p);

    always_comb begin
        unique case (acc_op.shift)
            gtp_pkg::SH_0:  addend = p_ext;
            gtp_pkg::SH_16: addend = p_ext <<< 16;
            gtp_pkg::SH_24: addend = p_ext <<< 24;
            gtp_pkg::SH_41: addend = p_ext <<< 41;
            gtp_pkg::SH_48: addend = p_ext <<< 48;
            gtp_pkg::SH_64: addend = p_ext <<< 64;
            gtp_pkg::SH_72: addend = p_ext <<< 72;
            default:        addend = p_ext;
        endcase
    end

    assign acc_next = acc_op.sub ? (r_acc - addend) : (r_acc + addend);

    // accumulator update with rounded coefficient product
    assign k_rnd   = r_k + K_HALF;
    assign term    = k_rnd[KB-1:FB];
    assign nv_wide = SUM_BITS'(r_x) + SUM_BITS'(term) - SUM_BITS'(r_a2);

    always_comb begin
        priority if (nv_wide > ACC_MAX) begin
            nv_sat = ACC_MAX[ACC_BITS-1:0];
            nv_ovf = 1'b1;
        end else if (nv_wide < ACC_MIN) begin
            nv_sat = ACC_MIN[ACC_BITS-1:0];
            nv_ovf = 1'b1;
        end else begin
            nv_sat = nv_wide[ACC_BITS-1:0];
            nv_ovf = 1'b0;
        end
    end

    // final rounding and saturation of the bin power
    assign acc_neg = r_acc[PAB-1];
    assign acc_big = |r_acc[PAB-1:FB+POWB];

    always_comb begin
        priority if (acc_neg) begin
            power = '0;
        end else if (acc_big) begin
            power = '1;
        end else begin
            power = r_acc[FB+POWB-1:FB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_a1        <= '0;
            r_a2        <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pop && r_out_valid && (r_state != ST_OUT)) begin
                r_out_valid <= 1'b0;
            end
            if (q_take) begin
                r_x    <= i_q_data[SAMPLE_BITS-1:0];
                r_last <= i_q_data[SAMPLE_BITS];
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (q_take) begin
                        r_state <= ST_UPD;
                        r_step  <= '0;
                    end
                end
                ST_UPD: begin
                    if (r_step == SB'(1)) begin
                        r_k <= KB'(mul_p);
                    end
                    if (r_step == SB'(2)) begin
                        r_k <= r_k + (KB'(mul_p) <<< PB);
                    end
                    if (r_step == UPD_LAST) begin
                        r_a2   <= r_a1;
                        r_a1   <= nv_sat;
                        r_step <= '0;
                        if (nv_ovf) begin
                            r_sat <= 1'b1;
                        end
                        if (r_last) begin
                            r_state <= ST_PWR;
                            r_acc   <= P_HALF;
                        end else if (!q_take) begin
                            r_state <= ST_IDLE;
                        end
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                ST_PWR: begin
                    if (r_step != '0) begin
                        r_acc <= acc_next;
                    end
                    if (r_step == PWR_END) begin
                        r_state <= ST_OUT;
                        r_step  <= '0;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                ST_OUT: begin
                    if (!r_out_valid || i_pop) begin
                        r_out_valid <= 1'b1;
                        r_power     <= power;
                        r_ovf       <= r_sat | (!acc_neg && acc_big);
                        r_a1        <= '0;
                        r_a2        <= '0;
                        r_sat       <= 1'b0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_bin_power = r_power;
    assign o_overflow  = r_ovf;

endmodule

// ----- hdl/goertzel_tone_power.sv -----
// ----------------------------------------------------------------------------
// goertzel_tone_power
// single-bin goertzel detector with queue-style sample and result ports
// ----------------------------------------------------------------------------
// Each sample takes the update steps in the arithmetic back end, and passes
// the idle state first when the back end was idle: the coefficient product
// needs two passes through the one shared 25x25 multiplier, then a step for
// rounding, the accumulator update and saturation. The sample that closes a
// window is followed by the bin power sequence, in which the same multiplier
// produces the twelve partial products of the bin power, and by a state that
// loads the result register; the back end then returns to idle before
// it takes the next sample. A four-item input queue lets samples arrive while
// a window's power is being worked out, and a result register keeps the back
// end free while a result waits to be popped, as long as the next window is
// not yet complete.
// ----------------------------------------------------------------------------
module goertzel_tone_power #(
    parameter int MAX_WINDOW  = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample,
    output logic                              empty,
    input  logic                              pop,
    output logic [gtp_pkg::POWER_BITS-1:0]    o_bin_power,
    output logic                              o_overflow,
    input  logic                              i_cfg_we,
    input  logic [gtp_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [gtp_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata
);

    localparam int QW = SAMPLE_BITS + 1;

    logic signed [gtp_pkg::COEFF_BITS-1:0] r_tone_coeff;
    logic [gtp_pkg::WLEN_BITS-1:0]         r_window_length;
    logic                                  q_wr;
    logic                                  q_rd;
    logic [QW-1:0]                         q_wdata;
    logic [QW-1:0]                         q_rdata;
    gtp_pkg::t_q_stat                      q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tone_coeff    <= '0;
            r_window_length <= gtp_pkg::WLEN_BITS'(gtp_pkg::WLEN_RESET);
        end else if (i_cfg_we) begin
            unique case (gtp_pkg::t_cfg_idx'(i_cfg_idx))
                gtp_pkg::CFG_TONE_COEFF: begin
                    r_tone_coeff <= i_cfg_wdata[gtp_pkg::COEFF_BITS-1:0];
                end
                gtp_pkg::CFG_WINDOW_LENGTH: begin
                    r_window_length <= i_cfg_wdata[gtp_pkg::WLEN_BITS-1:0];
                end
                default: begin
                    r_tone_coeff <= r_tone_coeff;
                end
            endcase
        end
    end

    gtp_front #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_sample (i_sample),
        .i_wlen   (r_window_length),
        .i_q_stat (q_stat),
        .o_full   (full),
        .o_q_wr   (q_wr),
        .o_q_data (q_wdata)
    );

    gtp_fifo #(
        .WIDTH (QW),
        .DEPTH (4)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (q_wdata),
        .i_rd    (q_rd),
        .o_rdata (q_rdata),
        .o_stat  (q_stat)
    );

    gtp_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_coeff     (r_tone_coeff),
        .i_q_data    (q_rdata),
        .i_q_stat    (q_stat),
        .o_q_rd      (q_rd),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_bin_power (o_bin_power),
        .o_overflow  (o_overflow)
    );

endmodule

// ----- hdl/gtp_checker.sv -----
// ----------------------------------------------------------------------------
// gtp_checker
// port-level checks of the tone detector, bound to the top level
// ----------------------------------------------------------------------------
module gtp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           push,
    input logic                           full,
    input logic                           empty,
    input logic                           pop,
    input logic [gtp_pkg::POWER_BITS-1:0] o_bin_power,
    input logic                           o_overflow
);

    // reset leaves no result and room for items
    a_reset_clear: assert property (
        @(posedge i_clk) !i_rst_n |=> (empty && !full)
    ) else $error("queues not cleared by reset");

    // a waiting result holds until popped
    a_result_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_bin_power) && $stable(o_overflow))
    ) else $error("waiting result changed or dropped");

    // the input queue fills only through a push
    a_full_on_push: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push)
    ) else $error("full rose without a pushed item");

endmodule

bind goertzel_tone_power gtp_checker u_gtp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .push        (push),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_bin_power (o_bin_power),
    .o_overflow  (o_overflow)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the single-bin goertzel tone power detector: samples
// are pushed through the input queue under random idling and stalls, an
// internal fixed-point predictor tracks the two accumulators, the window count
// and the saturation flag, and every popped bin power is compared in order
// ----------------------------------------------------------------------------
module testbench;

    localparam int MAX_WIN       = 4096;
    localparam int SMP_BITS      = 16;
    localparam int SETTLE_CYCLES = 64;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int LONG_ITEMS    = 512;
    localparam int RANDOM_ITEMS  = 600;
    localparam int RANDOM_WINS   = 16;

    typedef logic signed [127:0] t_wide;

    typedef struct packed {
        logic [gtp_pkg::POWER_BITS-1:0] power;
        logic                           ovf;
    } t_bin_power;

    typedef enum int {
        MIX_UNIFORM,
        MIX_FULL_SCALE,
        MIX_SMALL
    } t_sample_mix;

    logic                               i_clk       = 1'b0;
    logic                               i_rst_n     = 1'b0;
    logic                               push        = 1'b0;
    logic                               full;
    logic signed [SMP_BITS-1:0]         i_sample    = '0;
    logic                               empty;
    logic                               pop         = 1'b0;
    logic [gtp_pkg::POWER_BITS-1:0]     o_bin_power;
    logic                               o_overflow;
    logic                               i_cfg_we    = 1'b0;
    logic [gtp_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx   = '0;
    logic [gtp_pkg::CFG_DATA_BITS-1:0]  i_cfg_wdata = '0;

    // predictor copy of the detector
    logic signed [gtp_pkg::COEFF_BITS-1:0] cur_coeff = '0;
    logic [gtp_pkg::WLEN_BITS-1:0]         cur_wlen  =
        gtp_pkg::WLEN_BITS'(gtp_pkg::WLEN_RESET);
    logic signed [gtp_pkg::ACC_BITS-1:0]   win_s1    = '0;
    logic signed [gtp_pkg::ACC_BITS-1:0]   win_s2    = '0;
    int                                    win_count = 0;
    logic                                  win_sat   = 1'b0;

    t_bin_power pending_powers[$];

    bit gaps_on       = 1'b1;
    int hold_request  = 0;
    int n_errors      = 0;
    int n_items       = 0;
    int n_windows     = 0;
    int n_checked     = 0;
    int n_ovf         = 0;
    int n_zero        = 0;
    int n_writes      = 0;
    int stall_count   = 0;

    goertzel_tone_power #(
        .MAX_WINDOW  (MAX_WIN),
        .SAMPLE_BITS (SMP_BITS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_sample    (i_sample),
        .empty       (empty),
        .pop         (pop),
        .o_bin_power (o_bin_power),
        .o_overflow  (o_overflow),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    function automatic bit goertzel_predict(input logic signed [SMP_BITS-1:0] smp,
                                            output t_bin_power res);
        t_wide x, k, a1, a2, nv, acc_max, acc_min, tot, q, power_max;
        int    len;
        res       = '0;
        x         = smp;
        k         = cur_coeff;
        a1        = win_s1;
        a2        = win_s2;
        acc_max   = (t_wide'(1) <<< (gtp_pkg::ACC_BITS - 1)) - 1;
        acc_min   = -acc_max - 1;
        power_max = (t_wide'(1) <<< gtp_pkg::POWER_BITS) - 1;
        nv = x + ((k * a1 + (t_wide'(1) <<< (gtp_pkg::FRAC_BITS - 1)))
                  >>> gtp_pkg::FRAC_BITS) - a2;
        if (nv > acc_max) begin
            nv      = acc_max;
            win_sat = 1'b1;
        end else if (nv < acc_min) begin
            nv      = acc_min;
            win_sat = 1'b1;
        end
        win_s2 = win_s1;
        win_s1 = nv[gtp_pkg::ACC_BITS-1:0];
        len = int'(cur_wlen);
        if (len < 1) len = 1;
        if (len > MAX_WIN) len = MAX_WIN;
        win_count++;
        if (win_count < len) return 1'b0;
        a1  = win_s1;
        a2  = win_s2;
        tot = ((a1 * a1 + a2 * a2) <<< gtp_pkg::FRAC_BITS) - k * a1 * a2
              + (t_wide'(1) <<< (gtp_pkg::FRAC_BITS - 1));
        res.ovf = win_sat;
        if (tot < 0) begin
            res.power = '0;
        end else begin
            q = tot >>> gtp_pkg::FRAC_BITS;
            if (q > power_max) begin
                res.power = '1;
                res.ovf   = 1'b1;
            end else begin
                res.power = q[gtp_pkg::POWER_BITS-1:0];
            end
        end
        win_s1    = '0;
        win_s2    = '0;
        win_count = 0;
        win_sat   = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic signed [SMP_BITS-1:0] pick_sample(input t_sample_mix mix);
        case (mix)
            MIX_FULL_SCALE: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            MIX_SMALL:      return 16'(int'($urandom_range(0, 64)) - 32);
            default:        return 16'($urandom());
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        n_errors++;
        $display("mismatch on %0s: got %0d, want %0d at %0t", what, got, want, $realtime);
    endtask

    task automatic send_sample(input logic signed [SMP_BITS-1:0] smp);
        t_bin_power want;
        while (gaps_on && $urandom_range(0, 99) < 13) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push     <= 1'b1;
        i_sample <= smp;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        n_items++;
        if (goertzel_predict(smp, want)) begin
            pending_powers = {pending_powers, want};
            n_windows++;
            if (want.ovf) n_ovf++;
            if (want.power == '0) n_zero++;
        end
    endtask

    task automatic drain_block();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_powers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input gtp_pkg::t_cfg_idx idx,
                             input logic [gtp_pkg::CFG_DATA_BITS-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        n_writes++;
        case (idx)
            gtp_pkg::CFG_TONE_COEFF:    cur_coeff = data;
            gtp_pkg::CFG_WINDOW_LENGTH: cur_wlen  = data[gtp_pkg::WLEN_BITS-1:0];
            default:                    ;
        endcase
    endtask

    task automatic test_reset_defaults();
        repeat (gtp_pkg::WLEN_RESET) send_sample(pick_sample(MIX_UNIFORM));
    endtask

    task automatic test_sample_extremes();
        drain_block();
        write_reg(gtp_pkg::CFG_TONE_COEFF, 19'd92682);
        write_reg(gtp_pkg::CFG_WINDOW_LENGTH, 19'd8);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sd21845);
        drain_block();
        write_reg(gtp_pkg::CFG_WINDOW_LENGTH, 19'd0);
        send_sample(16'sh8000);
        send_sample(16'sh7fff);
    endtask

    task automatic test_power_limits();
        drain_block();
        write_reg(gtp_pkg::CFG_TONE_COEFF, 19'h3ffff);
        write_reg(gtp_pkg::CFG_WINDOW_LENGTH, 19'd2);
        // opposite-sign pairs drive the power below zero
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sd20000);
        send_sample(-16'sd15000);
        drain_block();
        write_reg(gtp_pkg::CFG_WINDOW_LENGTH, 19'd8191);
        repeat (14) send_sample(16'sh7fff);
        drain_block();
        // large state with a zero coefficient gives a power past 63 bits
        write_reg(gtp_pkg::CFG_TONE_COEFF, 19'd0);
        write_reg(gtp_pkg::CFG_WINDOW_LENGTH, 19'd1);
        send_sample(16'sh0000);
        drain_block();
        write_reg(gtp_pkg::CFG_TONE_COEFF, 19'h3ffff);
        write_reg(gtp_pkg::CFG_WINDOW_LENGTH, 19'd20);
        repeat (20) send_sample(16'sh7fff);
        drain_block();
        write_reg(gtp_pkg::CFG_TONE_COEFF, 19'h40000);
        repeat (20) send_sample(16'sh8000);
    endtask

    task automatic test_midwindow_writes();
        drain_block();
        write_reg(gtp_pkg::CFG_WINDOW_LENGTH, 19'd8191);
        write_reg(gtp_pkg::CFG_TONE_COEFF, 19'd80000);
        repeat (30) send_sample(pick_sample(MIX_UNIFORM));
        drain_block();
        write_reg(gtp_pkg::CFG_TONE_COEFF, -19'sd50000);
        repeat (5) send_sample(pick_sample(MIX_UNIFORM));
        drain_block();
        // count already past the new length, next item closes the window
        write_reg(gtp_pkg::CFG_WINDOW_LENGTH, 19'd10);
        send_sample(pick_sample(MIX_UNIFORM));
        repeat (10) send_sample(pick_sample(MIX_UNIFORM));
    endtask

    task automatic test_full_windows();
        drain_block();
        write_reg(gtp_pkg::CFG_TONE_COEFF, 19'd125413);
        write_reg(gtp_pkg::CFG_WINDOW_LENGTH, 19'd5000);
        repeat (LONG_ITEMS) send_sample(pick_sample(MIX_SMALL));
        drain_block();
        // a length past the maximum keeps the window open, shortening it closes it
        write_reg(gtp_pkg::CFG_WINDOW_LENGTH, 19'(LONG_ITEMS));
        send_sample(pick_sample(MIX_UNIFORM));
    endtask

    task automatic test_result_backpressure();
        drain_block();
        write_reg(gtp_pkg::CFG_WINDOW_LENGTH, 19'd1);
        hold_request = HOLD_CYCLES;
        repeat (24) send_sample(pick_sample(MIX_UNIFORM));
        drain_block();
    endtask

    task automatic test_random_windows();
        int          sent, closed_at_start, phase, coeff_v, wlen, eff, count, pause_at;
        t_sample_mix mix;
        logic [gtp_pkg::CFG_DATA_BITS-1:0] wdata;
        sent            = 0;
        phase           = 0;
        closed_at_start = n_windows;
        while (sent < RANDOM_ITEMS || n_windows - closed_at_start < RANDOM_WINS) begin
            drain_block();
            gaps_on = (phase < 3 || phase > 5);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: coeff_v = int'($urandom_range(0, 262144)) - 131072;
                6, 7:             coeff_v = int'($urandom());
                default: begin
                    case ($urandom_range(0, 4))
                        0:       coeff_v = -262144;
                        1:       coeff_v = 262143;
                        2:       coeff_v = 131072;
                        3:       coeff_v = -131072;
                        default: coeff_v = 0;
                    endcase
                end
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: wlen = $urandom_range(1, 24);
                7:                   wlen = 0;
                default:             wlen = $urandom_range(25, 200);
            endcase
            eff   = (wlen == 0) ? 1 : wlen;
            count = eff * $urandom_range(1, 3) + $urandom_range(0, eff - 1);
            wdata = gtp_pkg::CFG_DATA_BITS'(wlen);
            if ($urandom_range(0, 3) == 0)
                wdata[gtp_pkg::CFG_DATA_BITS-1:gtp_pkg::WLEN_BITS] =
                    (gtp_pkg::CFG_DATA_BITS - gtp_pkg::WLEN_BITS)'($urandom());
            write_reg(gtp_pkg::CFG_TONE_COEFF, coeff_v[gtp_pkg::CFG_DATA_BITS-1:0]);
            write_reg(gtp_pkg::CFG_WINDOW_LENGTH, wdata);
            case ($urandom_range(0, 3))
                0, 1:    mix = MIX_UNIFORM;
                2:       mix = MIX_FULL_SCALE;
                default: mix = MIX_SMALL;
            endcase
            pause_at = ($urandom_range(0, 3) == 0) ? count / 2 : -1;
            if ($urandom_range(0, 7) == 0) hold_request = $urandom_range(20, 80);
            for (int n = 0; n < count; n++) begin
                if (n == pause_at) drain_block();
                send_sample(pick_sample(mix));
            end
            sent += count;
            phase++;
        end
        gaps_on = 1'b1;
    endtask

    initial begin : result_check
        t_bin_power want;
        int         hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                n_checked++;
                if (pending_powers.size() == 0) begin
                    report_mismatch("unexpected item", 64'(o_bin_power), 64'd0);
                end else begin
                    want = pending_powers.pop_front();
                    if (o_bin_power !== want.power)
                        report_mismatch("bin_power", 64'(o_bin_power), 64'(want.power));
                    if (o_overflow !== want.ovf)
                        report_mismatch("overflow", 64'(o_overflow), 64'(want.ovf));
                end
            end
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end else begin
                pop <= !(gaps_on && $urandom_range(0, 99) < 13);
            end
        end
    end

    initial begin : watchdog
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (push && !full) || (pop && !empty)) begin
                stall_count = 0;
            end else if (stall_count >= STALL_LIMIT) begin
                $display("no item moved for %0d cycles", STALL_LIMIT);
                $display("goertzel_tone_power verification failed");
                $finish;
            end else begin
                stall_count++;
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_sample_extremes();
        test_power_limits();
        test_midwindow_writes();
        test_result_backpressure();
        test_full_windows();
        test_random_windows();
        drain_block();
        $display("covered %0d samples and %0d windows (%0d flagged overflow, %0d zero power)",
                 n_items, n_checked, n_ovf, n_zero);
        $display("%0d register writes, incl. mid-window changes and out-of-range lengths",
                 n_writes);
        if (n_errors == 0) begin
            $display("goertzel_tone_power verification clean");
        end else begin
            $display("goertzel_tone_power verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/gtp_pkg.sv
hdl/gtp_fifo.sv
hdl/gtp_front.sv
hdl/gtp_mul.sv
hdl/gtp_back.sv
hdl/goertzel_tone_power.sv
hdl/gtp_checker.sv
tb/testbench.sv
